// ===== hw/rtl/ledbcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledbcm_pkg
// Shared widths, codes, types and helper functions of the bit-plane driver.
// ----------------------------------------------------------------------------
package ledbcm_pkg;

    localparam int SIDE        = 16;
    localparam int LANES       = 8;
    localparam int ROWS        = (SIDE * SIDE) / LANES;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int LANE_W      = $clog2(LANES);
    localparam int COORD_W     = $clog2(SIDE);
    localparam int LED_W       = ROW_W + LANE_W;
    localparam int LEVEL_W     = 8;
    localparam int ROW_BITS    = LANES * LEVEL_W;
    localparam int TIME_W      = 11;
    localparam int BRIGHT_W    = 8;
    localparam int PROD_W      = TIME_W + BRIGHT_W;
    localparam int QUOT_W      = TIME_W + 1;
    localparam int RESID_W     = 10;
    localparam int PLANE_W     = 2;
    localparam int PLANE_SLOTS = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    localparam int PLANE_COUNT_DEF = 4;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'd255;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ZERO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ONE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_TWO    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_THREE  = 3'd7;

    localparam logic [LEVEL_W-1:0]  LEVEL_ONE_RST   = 8'd3;
    localparam logic [LEVEL_W-1:0]  LEVEL_TWO_RST   = 8'd7;
    localparam logic [LEVEL_W-1:0]  LEVEL_THREE_RST = 8'd15;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST      = 8'd255;
    localparam logic [TIME_W-1:0]   TIME_ZERO_RST   = 11'd50;
    localparam logic [TIME_W-1:0]   TIME_ONE_RST    = 11'd100;
    localparam logic [TIME_W-1:0]   TIME_TWO_RST    = 11'd200;
    localparam logic [TIME_W-1:0]   TIME_THREE_RST  = 11'd400;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR_READ,
        ST_WR_MERGE,
        ST_SCAN
    } drv_state_t;

    typedef enum logic [1:0] {
        OT_IDLE,
        OT_ESTIMATE,
        OT_CORRECT
    } ot_phase_t;

    typedef struct packed {
        logic                rd_en;
        logic [ROW_W-1:0]    rd_addr;
        logic                wr_en;
        logic [ROW_W-1:0]    wr_addr;
        logic [ROW_BITS-1:0] wr_data;
        logic                fill_en;
        logic [LEVEL_W-1:0]  fill_level;
    } pix_ctrl_t;

    function automatic logic [LEVEL_W-1:0] quantize(
        input logic [LEVEL_W-1:0] v,
        input logic [LEVEL_W-1:0] l1,
        input logic [LEVEL_W-1:0] l2,
        input logic [LEVEL_W-1:0] l3
    );
        logic [LEVEL_W-1:0] q;
        begin
            if (v == '0)
                q = '0;
            else if (v <= l1)
                q = l1;
            else if (v <= l2)
                q = l2;
            else
                q = l3;
            return q;
        end
    endfunction

    // Panel wiring: row pairs form 32-LED bands, each half a 16-LED serpentine.
    function automatic logic [LED_W-1:0] led_of(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c
    );
        logic [2:0] pair;
        logic       odd;
        logic       right;
        logic       b0;
        logic [2:0] cm;
        begin
            pair  = r[3:1];
            odd   = r[0];
            right = c[3];
            cm    = c[2:0];
            b0    = ~(pair[0] ^ right);
            return {pair, b0, odd, (odd ? cm : ~cm)};
        end
    endfunction

endpackage

// ===== hw/rtl/ledbcm_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledbcm_stream_if
// Valid/ready channels for pixel commands and shift beats.
// ----------------------------------------------------------------------------
interface ledbcm_in_if;
    import ledbcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LEVEL_W-1:0] value;

    modport source (output valid, output mode, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input mode, input row, input col, input value,
                    output ready);
endinterface

interface ledbcm_out_if;
    import ledbcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         shift_byte;
    logic [PLANE_W-1:0] plane_number;
    logic               last_byte;
    logic [TIME_W-1:0]  on_time_us;

    modport source (output valid, output shift_byte, output plane_number,
                    output last_byte, output on_time_us, input ready);
    modport sink   (input valid, input shift_byte, input plane_number,
                    input last_byte, input on_time_us, output ready);
endinterface

// ===== hw/rtl/led_matrix_bitplane_scan_driver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scan_driver
// 16x16 LED matrix bit-plane driver: quantized pixel store, refresh scan
// emitting 32 shift beats per plane through the panel wiring.
// Pixel write: accept, row read, then merge and write back.
// Fill: row valid bits clear, fill level taken by all rows.
// Refresh: one beat per cycle while the output is not stalled, one memory
//   row read per beat; the last beat also waits for the on-time result.
// Reset: registers take their defaults, pixels read as 0, plane 0; no sweep.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_scan_driver #(
    parameter int PLANE_COUNT = ledbcm_pkg::PLANE_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ledbcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ledbcm_pkg::CFG_DATA_W-1:0]    cfg_data,
    ledbcm_in_if.sink                            pixel_in,
    ledbcm_out_if.source                         plane_out
);
    import ledbcm_pkg::*;

    logic [LEVEL_W-1:0]  level_one_reg;
    logic [LEVEL_W-1:0]  level_two_reg;
    logic [LEVEL_W-1:0]  level_three_reg;
    logic [BRIGHT_W-1:0] brightness_reg;
    logic [TIME_W-1:0]   plane_time_reg [PLANE_SLOTS];

    drv_state_t          state_reg, state_next;
    logic [PLANE_W-1:0]  plane_reg, plane_next;
    logic [LED_W-1:0]    wr_led_reg, wr_led_next;
    logic [LEVEL_W-1:0]  wr_level_reg, wr_level_next;
    logic [ROW_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                issue_done_reg, issue_done_next;
    logic                pend_reg, pend_next;
    logic [ROW_W-1:0]    pend_idx_reg, pend_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg;
    logic [PLANE_W-1:0]  out_plane_reg;
    logic                out_last_reg;
    logic [TIME_W-1:0]   out_time_reg;

    pix_ctrl_t           ctrl;
    logic [ROW_BITS-1:0] rd_row;
    logic [ROW_BITS-1:0] merged_row;
    logic [7:0]          scan_byte;
    logic [LEVEL_W-1:0]  threshold;
    logic                out_free;
    logic                load;
    logic                load_last;
    logic                issue;
    logic                ot_start;
    logic                ot_done;
    logic [TIME_W-1:0]   ot_value;

    ledbcm_pixel_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .rd_row (rd_row)
    );

    ledbcm_on_time u_on_time (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ot_start),
        .plane_time (plane_time_reg[plane_reg]),
        .brightness (brightness_reg),
        .on_time    (ot_value),
        .done       (ot_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_one_reg     <= LEVEL_ONE_RST;
            level_two_reg     <= LEVEL_TWO_RST;
            level_three_reg   <= LEVEL_THREE_RST;
            brightness_reg    <= BRIGHT_RST;
            plane_time_reg[0] <= TIME_ZERO_RST;
            plane_time_reg[1] <= TIME_ONE_RST;
            plane_time_reg[2] <= TIME_TWO_RST;
            plane_time_reg[3] <= TIME_THREE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEVEL_ONE:   level_one_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_TWO:   level_two_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_THREE: level_three_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_BRIGHTNESS:  brightness_reg    <= cfg_data[BRIGHT_W-1:0];
                CFG_TIME_ZERO:   plane_time_reg[0] <= cfg_data[TIME_W-1:0];
                CFG_TIME_ONE:    plane_time_reg[1] <= cfg_data[TIME_W-1:0];
                CFG_TIME_TWO:    plane_time_reg[2] <= cfg_data[TIME_W-1:0];
                CFG_TIME_THREE:  plane_time_reg[3] <= cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Row merge for a pixel write, plane thresholding for a scan beat
    assign threshold = LEVEL_W'(1) << plane_reg;

    always_comb
    begin
        merged_row = rd_row;
        for (int i = 0; i < LANES; i++)
        begin
            if (wr_led_reg[LANE_W-1:0] == LANE_W'(i))
            begin
                merged_row[i*LEVEL_W +: LEVEL_W] = wr_level_reg;
            end
            scan_byte[LANES-1-i] = (rd_row[i*LEVEL_W +: LEVEL_W] >= threshold);
        end
    end

    assign out_free  = !out_valid_reg || plane_out.ready;
    assign load_last = (pend_idx_reg == ROW_W'(ROWS - 1));
    assign load      = (state_reg == ST_SCAN) && pend_reg && out_free
                       && (!load_last || ot_done);
    assign issue     = (state_reg == ST_SCAN) && !issue_done_reg && (!pend_reg || load);

    assign pixel_in.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        plane_next      = plane_reg;
        wr_led_next     = wr_led_reg;
        wr_level_next   = wr_level_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        ot_start        = 1'b0;
        ctrl            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_in.valid)
                begin
                    case (pixel_in.mode)
                        MODE_WRITE:
                        begin
                            wr_led_next   = led_of(pixel_in.row, pixel_in.col);
                            wr_level_next = quantize(pixel_in.value, level_one_reg,
                                                     level_two_reg, level_three_reg);
                            state_next    = ST_WR_READ;
                        end
                        MODE_FILL:
                        begin
                            ctrl.fill_en    = 1'b1;
                            ctrl.fill_level = quantize(pixel_in.value, level_one_reg,
                                                       level_two_reg, level_three_reg);
                        end
                        MODE_REFRESH:
                        begin
                            ot_start        = 1'b1;
                            scan_addr_next  = '0;
                            issue_done_next = 1'b0;
                            pend_next       = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WR_READ:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_addr = wr_led_reg[LED_W-1:LANE_W];
                state_next   = ST_WR_MERGE;
            end
            ST_WR_MERGE:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_addr = wr_led_reg[LED_W-1:LANE_W];
                ctrl.wr_data = merged_row;
                state_next   = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    ctrl.rd_en     = 1'b1;
                    ctrl.rd_addr   = scan_addr_reg;
                    scan_addr_next = scan_addr_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = scan_addr_reg;
                    if (scan_addr_reg == ROW_W'(ROWS - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                else if (load)
                begin
                    pend_next = 1'b0;
                end
                if (issue_done_reg && !pend_reg)
                begin
                    state_next = ST_IDLE;
                    plane_next = (plane_reg == PLANE_W'(PLANE_COUNT - 1)) ?
                                 '0 : plane_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (plane_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            plane_reg      <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            plane_reg      <= plane_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_led_reg    <= wr_led_next;
        wr_level_reg  <= wr_level_next;
        scan_addr_reg <= scan_addr_next;
        pend_idx_reg  <= pend_idx_next;
        if (load)
        begin
            out_byte_reg  <= scan_byte;
            out_plane_reg <= plane_reg;
            out_last_reg  <= load_last;
            out_time_reg  <= load_last ? ot_value : '0;
        end
    end

    assign plane_out.valid        = out_valid_reg;
    assign plane_out.shift_byte   = out_byte_reg;
    assign plane_out.plane_number = out_plane_reg;
    assign plane_out.last_byte    = out_last_reg;
    assign plane_out.on_time_us   = out_time_reg;

    a_refresh_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_in.valid && pixel_in.ready && pixel_in.mode == MODE_REFRESH)
        |=> (state_reg == ST_SCAN))
        else $error("refresh beat did not start a scan");

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg <= PLANE_W'(PLANE_COUNT - 1))
        else $error("plane index out of range");

    a_no_pending_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> !pend_reg)
        else $error("row pending outside a scan");

    a_plane_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_SCAN && state_reg == ST_IDLE)
        |-> (plane_reg == (($past(plane_reg) == PLANE_W'(PLANE_COUNT - 1)) ?
                           PLANE_W'(0) : PLANE_W'($past(plane_reg) + 1'b1))))
        else $error("plane index did not advance after a scan");

    a_time_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (plane_out.valid && !plane_out.last_byte) |-> (plane_out.on_time_us == '0))
        else $error("on time shown on a beat other than the last");

endmodule

// ===== hw/rtl/ledbcm_pixel_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledbcm_pixel_store
// Pixel level memory, one row per shift byte, with row valid bits and a
// fill level returned for rows not written since reset or the last fill.
// ----------------------------------------------------------------------------
module ledbcm_pixel_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ledbcm_pkg::pix_ctrl_t               ctrl,
    output logic [ledbcm_pkg::ROW_BITS-1:0]     rd_row
);
    import ledbcm_pkg::*;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] mem_q;
    logic [ROWS-1:0]     valid_reg;
    logic [LEVEL_W-1:0]  fill_reg;
    logic                hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            mem_q <= mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.fill_en)
            begin
                valid_reg <= '0;
                fill_reg  <= ctrl.fill_level;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                hit_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_row = hit_reg ? mem_q : {LANES{fill_reg}};

endmodule

// ===== hw/rtl/ledbcm_on_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledbcm_on_time
// Output-enable time: plane_time * brightness / 255 by reciprocal estimate
// and compare-subtract correction.
// ----------------------------------------------------------------------------
module ledbcm_on_time (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ledbcm_pkg::TIME_W-1:0]       plane_time,
    input  logic [ledbcm_pkg::BRIGHT_W-1:0]     brightness,
    output logic [ledbcm_pkg::TIME_W-1:0]       on_time,
    output logic                                done
);
    import ledbcm_pkg::*;

    ot_phase_t            phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [RESID_W-1:0]   resid_reg, resid_next;
    logic [PROD_W+8:0]    scaled;
    logic [QUOT_W-1:0]    est;
    logic [PROD_W:0]      resid_full;

    // x * 257 / 65536 never overshoots x / 255 and falls short by at most two
    assign scaled     = {9'd0, prod_reg} + {1'b0, prod_reg, 8'd0};
    assign est        = scaled[PROD_W+8:16];
    assign resid_full = {1'b0, prod_reg} - {est, 8'd0} + (PROD_W+1)'(est);

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = done_reg;
        prod_next  = prod_reg;
        quot_next  = quot_reg;
        resid_next = resid_reg;
        if (start)
        begin
            prod_next  = {8'd0, plane_time} * {11'd0, brightness};
            done_next  = 1'b0;
            phase_next = OT_ESTIMATE;
        end
        else
        begin
            case (phase_reg)
                OT_IDLE:
                begin
                end
                OT_ESTIMATE:
                begin
                    quot_next  = est;
                    resid_next = resid_full[RESID_W-1:0];
                    phase_next = OT_CORRECT;
                end
                OT_CORRECT:
                begin
                    if (resid_reg >= RESID_W'(BRIGHT_MAX))
                    begin
                        quot_next  = quot_reg + 1'b1;
                        resid_next = resid_reg - RESID_W'(BRIGHT_MAX);
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        phase_next = OT_IDLE;
                    end
                end
                default:
                begin
                    phase_next = OT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= OT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        quot_reg  <= quot_next;
        resid_reg <= resid_next;
    end

    assign on_time = quot_reg[TIME_W-1:0];
    assign done    = done_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED matrix bit-plane driver. Pixel writes,
// fills and refresh ticks go in over a valid/ready channel. A behavioral
// mirror of the pixel store, plane counter and registers predicts the 32
// shift beats of every refresh. Each beat is compared in order, field by
// field. Both sides idle at random. One long output hold fills the block.
// ----------------------------------------------------------------------------
module tb_top;
    import ledbcm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int BEATS_PER_PLANE = 32;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 8;

    typedef struct {
        logic [7:0]         bits;
        logic [PLANE_W-1:0] plane;
        logic               last;
        logic [TIME_W-1:0]  on_time;
    } beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ledbcm_in_if  pixel_if ();
    ledbcm_out_if plane_if ();

    led_matrix_bitplane_scan_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixel_if),
        .plane_out (plane_if)
    );

    // mirror of the block state
    logic [LEVEL_W-1:0]  level_mirror [SIDE*SIDE];
    logic [PLANE_W-1:0]  plane_mirror;
    logic [LEVEL_W-1:0]  lvl_one;
    logic [LEVEL_W-1:0]  lvl_two;
    logic [LEVEL_W-1:0]  lvl_three;
    logic [BRIGHT_W-1:0] bright;
    logic [TIME_W-1:0]   plane_time [PLANE_SLOTS];

    beat_t pending_beats [$];
    int    fails        = 0;
    bit    calm         = 1'b0;
    bit    hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void reset_mirror();
        foreach (level_mirror[i])
            level_mirror[i] = '0;
        plane_mirror  = '0;
        lvl_one       = LEVEL_ONE_RST;
        lvl_two       = LEVEL_TWO_RST;
        lvl_three     = LEVEL_THREE_RST;
        bright        = BRIGHT_RST;
        plane_time[0] = TIME_ZERO_RST;
        plane_time[1] = TIME_ONE_RST;
        plane_time[2] = TIME_TWO_RST;
        plane_time[3] = TIME_THREE_RST;
    endfunction

    function automatic logic [LEVEL_W-1:0] quantize_level(input logic [LEVEL_W-1:0] v);
        if (v == '0)
            return '0;
        if (v <= lvl_one)
            return lvl_one;
        if (v <= lvl_two)
            return lvl_two;
        return lvl_three;
    endfunction

    // Each row pair is a 32-LED band; the half holding LEDs 16..31 alternates
    // side by band, even rows run right to left.
    function automatic int led_position(input int r, input int c);
        int pair;
        int half;
        pair = r / 2;
        half = ((c >= 8) == (pair % 2 == 1)) ? 16 : 0;
        return 32 * pair + half + 8 * (r % 2) + ((r % 2 == 1) ? c % 8 : 7 - c % 8);
    endfunction

    function automatic void predict_plane_beats();
        logic [7:0] plane_bytes [BEATS_PER_PLANE];
        int         threshold;
        int         led;
        int         scaled;
        beat_t      b;
        threshold = 1 << plane_mirror;
        foreach (plane_bytes[k])
            plane_bytes[k] = '0;
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                if (int'(level_mirror[r*SIDE+c]) >= threshold)
                begin
                    led = led_position(r, c);
                    plane_bytes[led/8][7-(led%8)] = 1'b1;
                end
        scaled = int'(plane_time[plane_mirror]) * int'(bright) / 255;
        for (int k = 0; k < BEATS_PER_PLANE; k++)
        begin
            b.bits    = plane_bytes[k];
            b.plane   = plane_mirror;
            b.last    = (k == BEATS_PER_PLANE - 1);
            b.on_time = b.last ? scaled[TIME_W-1:0] : '0;
            pending_beats.push_back(b);
        end
        plane_mirror = plane_mirror + 1'b1;
    endfunction

    function automatic void apply_item(input logic [MODE_W-1:0] mode,
                                       input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] col,
                                       input logic [LEVEL_W-1:0] value);
        logic [LEVEL_W-1:0] q;
        q = quantize_level(value);
        case (mode)
            MODE_WRITE:   level_mirror[{row, col}] = q;
            MODE_FILL:    foreach (level_mirror[i]) level_mirror[i] = q;
            MODE_REFRESH: predict_plane_beats();
            default:      ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return LEVEL_W'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return lvl_one;
            2:       return lvl_one + 1'b1;
            3:       return lvl_two;
            4:       return lvl_two + 1'b1;
            default: return 8'hff;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_LEVEL_ONE:   lvl_one       = data[LEVEL_W-1:0];
            CFG_LEVEL_TWO:   lvl_two       = data[LEVEL_W-1:0];
            CFG_LEVEL_THREE: lvl_three     = data[LEVEL_W-1:0];
            CFG_BRIGHTNESS:  bright        = data[BRIGHT_W-1:0];
            CFG_TIME_ZERO:   plane_time[0] = data[TIME_W-1:0];
            CFG_TIME_ONE:    plane_time[1] = data[TIME_W-1:0];
            CFG_TIME_TWO:    plane_time[2] = data[TIME_W-1:0];
            CFG_TIME_THREE:  plane_time[3] = data[TIME_W-1:0];
            default:         ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input int l1, input int l2, input int l3, input int br,
                             input int t0, input int t1, input int t2, input int t3);
        write_reg(CFG_LEVEL_ONE, CFG_DATA_W'(l1));
        write_reg(CFG_LEVEL_TWO, CFG_DATA_W'(l2));
        write_reg(CFG_LEVEL_THREE, CFG_DATA_W'(l3));
        write_reg(CFG_BRIGHTNESS, CFG_DATA_W'(br));
        write_reg(CFG_TIME_ZERO, CFG_DATA_W'(t0));
        write_reg(CFG_TIME_ONE, CFG_DATA_W'(t1));
        write_reg(CFG_TIME_TWO, CFG_DATA_W'(t2));
        write_reg(CFG_TIME_THREE, CFG_DATA_W'(t3));
    endtask

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col, input logic [LEVEL_W-1:0] value);
        int gap;
        pixel_if.valid <= 1'b1;
        pixel_if.mode  <= mode;
        pixel_if.row   <= row;
        pixel_if.col   <= col;
        pixel_if.value <= value;
        do
            @(posedge clk);
        while (!pixel_if.ready);
        apply_item(mode, row, col, value);
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // input idle, every beat out, then a margin for a pixel write in flight
    task automatic settle_block();
        pixel_if.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_traffic(input int count);
        int r;
        logic [MODE_W-1:0] mode;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                mode = MODE_WRITE;
            else if (r < 62)
                mode = MODE_FILL;
            else if (r < 93)
                mode = MODE_REFRESH;
            else
                mode = MODE_SPARE;
            send_item(mode, COORD_W'($urandom_range(0, 15)),
                      COORD_W'($urandom_range(0, 15)), pick_value());
        end
    endtask

    task automatic check_reset_state();
        repeat (PLANE_SLOTS) send_item(MODE_REFRESH, 4'd0, 4'd0, 8'd0);
        send_item(MODE_FILL, 4'd15, 4'd15, 8'hff);
        repeat (PLANE_SLOTS) send_item(MODE_REFRESH, 4'd0, 4'd0, 8'd0);
        settle_block();
    endtask

    task automatic check_quantize_corners();
        send_item(MODE_FILL, 4'd0, 4'd0, 8'd0);
        send_item(MODE_WRITE, 4'd0, 4'd0, 8'd1);
        send_item(MODE_WRITE, 4'd0, 4'd15, 8'd3);
        send_item(MODE_WRITE, 4'd15, 4'd0, 8'd4);
        send_item(MODE_WRITE, 4'd15, 4'd15, 8'd7);
        send_item(MODE_WRITE, 4'd7, 4'd8, 8'd8);
        send_item(MODE_WRITE, 4'd8, 4'd7, 8'hff);
        send_item(MODE_WRITE, 4'd15, 4'd15, 8'd0);
        send_item(MODE_SPARE, 4'd5, 4'd5, 8'hff);
        repeat (PLANE_SLOTS) send_item(MODE_REFRESH, 4'd0, 4'd0, 8'd0);
        settle_block();
    endtask

    task automatic check_register_sweep();
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        random_traffic(80);
        settle_block();
        write_all(255, 255, 255, 255, 2047, 2000, 2047, 2000);
        random_traffic(80);
        settle_block();
        write_all(200, 9, 1, 128, 2000, 1, 1023, 1024);
        calm = 1'b1;
        random_traffic(80);
        calm = 1'b0;
        settle_block();
        repeat (3)
        begin
            write_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
            random_traffic(70);
            settle_block();
        end
    endtask

    task automatic check_output_backpressure();
        write_all(3, 7, 15, 255, 50, 100, 200, 400);
        calm         = 1'b1;
        hold_request = 1'b1;
        repeat (12)
        begin
            send_item(MODE_REFRESH, 4'd0, 4'd0, 8'd0);
            send_item(MODE_WRITE, COORD_W'($urandom_range(0, 15)),
                      COORD_W'($urandom_range(0, 15)), pick_value());
        end
        calm = 1'b0;
        settle_block();
    endtask

    // output side: random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left     = 0;
        plane_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                plane_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                plane_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                plane_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                plane_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin : beat_check
        beat_t want;
        if (rst_n && plane_if.valid && plane_if.ready)
        begin
            if (pending_beats.size() == 0)
            begin
                fails++;
                $display("%0t: beat with none pending: byte=%h plane=%0d last=%b on=%0d",
                         $time, plane_if.shift_byte, plane_if.plane_number,
                         plane_if.last_byte, plane_if.on_time_us);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (plane_if.shift_byte !== want.bits || plane_if.plane_number !== want.plane ||
                    plane_if.last_byte !== want.last || plane_if.on_time_us !== want.on_time)
                begin
                    fails++;
                    $display("%0t: beat mismatch exp byte=%h plane=%0d last=%b on=%0d", $time,
                             want.bits, want.plane, want.last, want.on_time);
                    $display("%0t:                got byte=%h plane=%0d last=%b on=%0d", $time,
                             plane_if.shift_byte, plane_if.plane_number,
                             plane_if.last_byte, plane_if.on_time_us);
                end
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        pixel_if.valid <= 1'b0;
        pixel_if.mode  <= MODE_WRITE;
        pixel_if.row   <= '0;
        pixel_if.col   <= '0;
        pixel_if.value <= '0;
        reset_mirror();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_state();
        check_quantize_corners();
        check_register_sweep();
        check_output_backpressure();

        settle_block();
        repeat (40) @(posedge clk);
        if (fails == 0 && pending_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
